// ===== sv/icba_pkg.sv =====
// Package for integer_to_base_ascii: character constants, radix limits,
// microcode word layout, step addresses and the digit-to-ASCII function.
// No dependencies.
package icba_pkg;

	// ASCII codes and digit constants
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_A         = 8'h41;
	localparam logic [7:0] CHAR_MINUS     = 8'h2D;
	localparam logic [5:0] DECIMAL_DIGITS = 6'd10;

	// Radix register limits and reset value
	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_RESET = 6'd10;

	// Microcode step addresses
	typedef logic [2:0] upc_t;
	localparam upc_t STEP_IDLE     = 3'd0;
	localparam upc_t STEP_DIV_INIT = 3'd1;
	localparam upc_t STEP_DIV      = 3'd2;
	localparam upc_t STEP_STORE    = 3'd3;
	localparam upc_t STEP_SIGN     = 3'd4;
	localparam upc_t STEP_EMIT     = 3'd5;

	// Branch conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_START,
		COND_BITS_LEFT,
		COND_MORE_DIGITS,
		COND_CHARS_LEFT
	} cond_t;

	// Datapath actions of one control word
	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic store;
		logic emit_sign;
		logic emit_digit;
		logic rd_issue;
	} icba_ctrl_t;

	// Full microcode word: actions plus two-way branch
	typedef struct packed {
		icba_ctrl_t ctrl;
		cond_t      cond;
		upc_t       addr_true;
		upc_t       addr_false;
	} icba_uword_t;

	// Datapath status fed back to the sequencer
	typedef struct packed {
		logic bits_left;
		logic more_digits;
		logic chars_left;
	} icba_status_t;

	// Digit value 0..35 to ASCII '0'..'9', 'A'..'Z'
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] d8;
		d8 = {2'b00, d};
		if (d < DECIMAL_DIGITS) begin
			return CHAR_ZERO + d8;
		end
		return CHAR_A + d8 - {2'b00, DECIMAL_DIGITS};
	endfunction

endpackage

// ===== sv/integer_to_base_ascii.sv =====
// Top level of integer_to_base_ascii: signed integer to ASCII text in a
// configurable radix. Depends on icba_pkg, icba_sequencer, icba_datapath.
//
// Usage:
//   Pulse start with value while busy is low; the transaction is taken at
//   that edge and busy rises. The text comes out one character per cycle
//   on char_code, marked by valid: an optional '-' and then the digits,
//   most significant first; last marks the final character.
//   radix is written through radix_we/radix_wdata while the block is idle;
//   values outside 2..36 are clamped. Reset sets the radix to ten.
// Sequence (D = number of digits, W = VALUE_WIDTH):
//   Each digit takes a pass of the shared bit-serial divider (clear,
//   W shift/subtract steps, store); the digits are produced one by one.
//   Then one sign step and D emit steps follow; a leading '-' is on char_code
//   first, after the sign step, and the digits follow in back-to-back cycles.
//   A new value is accepted only once the sequencer is back in idle.
//   The receiver cannot stall: each character is shown for one cycle only.
//   Reset aborts any conversion and returns the sequencer to idle.
module integer_to_base_ascii import icba_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          radix_we,
	input  logic [5:0]                    radix_wdata,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          busy,
	output logic                          valid,
	output logic [7:0]                    char_code,
	output logic                          last
);

	icba_ctrl_t   ctrl;
	icba_status_t status;

	// Microcode sequencer
	icba_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Divider, digit store and output registers
	icba_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.value       (value),
		.ctrl        (ctrl),
		.status      (status),
		.valid       (valid),
		.char_code   (char_code),
		.last        (last)
	);

	// An accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// Characters of one value leave in consecutive cycles
	a_chars_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("gap inside a character run");

	// The final character ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("character after last");

	// No character while idle and no run has just ended
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("character outside a conversion");

endmodule

// ===== sv/icba_sequencer.sv =====
// Microcode sequencer for integer_to_base_ascii: step counter, control ROM
// and branch logic. Depends on icba_pkg.
module icba_sequencer import icba_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  icba_status_t status,
	output icba_ctrl_t   ctrl,
	output logic         busy
);

	upc_t        upc_q;
	upc_t        upc_next;
	icba_uword_t word;
	logic        take;

	// Control ROM
	function automatic icba_uword_t rom(input upc_t a);
		icba_uword_t w;
		w = '0;
		unique case (a)
			STEP_IDLE: begin
				w.ctrl.load = 1'b1;
				w.cond = COND_START;
				w.addr_true = STEP_DIV_INIT;
				w.addr_false = STEP_IDLE;
			end
			STEP_DIV_INIT: begin
				w.ctrl.div_init = 1'b1;
				w.cond = COND_NEVER;
				w.addr_true = STEP_DIV;
				w.addr_false = STEP_DIV;
			end
			STEP_DIV: begin
				w.ctrl.div_step = 1'b1;
				w.cond = COND_BITS_LEFT;
				w.addr_true = STEP_DIV;
				w.addr_false = STEP_STORE;
			end
			STEP_STORE: begin
				w.ctrl.store = 1'b1;
				w.cond = COND_MORE_DIGITS;
				w.addr_true = STEP_DIV_INIT;
				w.addr_false = STEP_SIGN;
			end
			STEP_SIGN: begin
				w.ctrl.emit_sign = 1'b1;
				w.ctrl.rd_issue = 1'b1;
				w.cond = COND_NEVER;
				w.addr_true = STEP_EMIT;
				w.addr_false = STEP_EMIT;
			end
			STEP_EMIT: begin
				w.ctrl.emit_digit = 1'b1;
				w.ctrl.rd_issue = 1'b1;
				w.cond = COND_CHARS_LEFT;
				w.addr_true = STEP_EMIT;
				w.addr_false = STEP_IDLE;
			end
			default: begin
				w.cond = COND_NEVER;
				w.addr_true = STEP_IDLE;
				w.addr_false = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign word = rom(upc_q);
	assign busy = (upc_q != STEP_IDLE);

	// Branch condition select
	always_comb begin
		unique case (word.cond)
			COND_NEVER:       take = 1'b0;
			COND_START:       take = start;
			COND_BITS_LEFT:   take = status.bits_left;
			COND_MORE_DIGITS: take = status.more_digits;
			COND_CHARS_LEFT:  take = status.chars_left;
			default:          take = 1'b0;
		endcase
		upc_next = take ? word.addr_true : word.addr_false;
	end

	// Load only fires on an accepted transaction
	always_comb begin
		ctrl = word.ctrl;
		ctrl.load = word.ctrl.load & start;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ===== sv/icba_datapath.sv =====
// Datapath for integer_to_base_ascii: radix register, bit-serial divider,
// digit buffer memory and output registers. Depends on icba_pkg.
module icba_datapath import icba_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          radix_we,
	input  logic [5:0]                    radix_wdata,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  icba_ctrl_t                    ctrl,
	output icba_status_t                  status,
	output logic                          valid,
	output logic [7:0]                    char_code,
	output logic                          last
);

	localparam int IDXW = $clog2(MAX_DIGITS);
	localparam int CNTW = $clog2(MAX_DIGITS + 1);
	localparam int BITW = $clog2(VALUE_WIDTH);
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MAX_DIGITS - 1);
	localparam logic [BITW-1:0] BIT_TOP  = BITW'(VALUE_WIDTH - 1);

	logic [5:0]             radix_q;
	logic [5:0]             base;
	logic [VALUE_WIDTH-1:0] v_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [5:0]             rem_q;
	logic [BITW-1:0]        bit_q;
	logic [CNTW-1:0]        cnt_q;
	logic [CNTW-1:0]        cnt_dec;
	logic                   neg_q;
	logic [6:0]             trial;
	logic [6:0]             diff;
	logic                   ge;
	logic [5:0]             digit_mem [MAX_DIGITS];
	logic [5:0]             rd_data_q;
	logic                   valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	// Saturate radix into 2..36
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	// Magnitude of the incoming value, unsigned so the most negative works
	assign v_u = value;
	assign mag = v_u[VALUE_WIDTH-1] ? (~v_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v_u;

	// One restoring division step
	assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
	assign ge    = (trial >= {1'b0, base});
	assign diff  = trial - {1'b0, base};

	assign cnt_dec = cnt_q - {{(CNTW-1){1'b0}}, 1'b1};

	// Divider, digit count and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q  <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			if (ctrl.load) begin
				quot_q <= mag;
				neg_q  <= v_u[VALUE_WIDTH-1];
				cnt_q  <= '0;
			end
			if (ctrl.div_init) begin
				rem_q <= '0;
				bit_q <= BIT_TOP;
			end
			if (ctrl.div_step) begin
				rem_q  <= ge ? diff[5:0] : trial[5:0];
				quot_q <= {quot_q[VALUE_WIDTH-2:0], ge};
				bit_q  <= bit_q - {{(BITW-1){1'b0}}, 1'b1};
			end
			if (ctrl.store) begin
				cnt_q <= cnt_q + {{(CNTW-1){1'b0}}, 1'b1};
			end
			if (ctrl.rd_issue) begin
				cnt_q <= cnt_dec;
			end
		end
	end

	// Digit buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctrl.store) begin
			digit_mem[cnt_q[IDXW-1:0]] <= rem_q;
		end
		if (ctrl.rd_issue) begin
			rd_data_q <= digit_mem[cnt_dec[IDXW-1:0]];
		end
	end

	// Status back to the sequencer
	assign status.bits_left   = (bit_q != '0);
	assign status.more_digits = (quot_q != '0) && (cnt_q != CNT_LAST);
	assign status.chars_left  = (cnt_q != '0);

	// Output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (ctrl.emit_sign & neg_q) | ctrl.emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (ctrl.emit_digit) begin
			char_q <= digit_char(rd_data_q);
			last_q <= (cnt_q == '0);
		end
	end

	assign valid     = valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for integer_to_base_ascii: drives signed values
// under a range of radix settings and checks every emitted character.
// Depends on icba_pkg and the integer_to_base_ascii RTL.
module tb import icba_pkg::*;;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} ascii_char_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              radix_we    = 1'b0;
	logic [5:0]        radix_wdata = 6'd0;
	logic              start       = 1'b0;
	logic signed [31:0] value      = '0;
	logic              busy;
	logic              valid;
	logic [7:0]        char_code;
	logic              last;

	logic [31:0]  pending_q[$];    // values waiting to be sent
	logic [31:0]  directed_q[$];   // fixed values for the next phase
	ascii_char_t  text_q[$];       // characters still to come, oldest first
	logic [5:0]   radix_shadow = RADIX_RESET;
	int           gap_left = 0;
	bit           steady = 1'b0;   // phase without idle cycles
	int           mismatch_count = 0;

	integer_to_base_ascii #(
		.VALUE_WIDTH(32),
		.MAX_DIGITS (32)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.valid      (valid),
		.char_code  (char_code),
		.last       (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Register values outside 2..36 saturate
	function automatic logic [5:0] clamp_radix(input logic [5:0] r);
		if (r < RADIX_MIN) begin
			return RADIX_MIN;
		end
		if (r > RADIX_MAX) begin
			return RADIX_MAX;
		end
		return r;
	endfunction

	// Queue up the text of one value: optional minus, digits MSB first
	function automatic void queue_text(input logic [31:0] v, input logic [5:0] r);
		logic [31:0] base;
		logic [31:0] mag;
		logic [5:0]  digits[$];
		logic [5:0]  d;
		ascii_char_t c;
		base = {26'd0, clamp_radix(r)};
		// two's complement negate; the most negative value stays exact unsigned
		mag = v[31] ? (~v + 32'd1) : v;
		digits.push_front(6'(mag % base));
		mag = mag / base;
		while (mag != 32'd0) begin
			digits.push_front(6'(mag % base));
			mag = mag / base;
		end
		if (v[31]) begin
			c.code = CHAR_MINUS;
			c.fin  = 1'b0;
			text_q.push_back(c);
		end
		for (int i = 0; i < digits.size(); i++) begin
			d = digits[i];
			c.code = (d < DECIMAL_DIGITS) ? (CHAR_ZERO + {2'b00, d})
			                              : (CHAR_A + {2'b00, d} - {2'b00, DECIMAL_DIGITS});
			c.fin  = (i == digits.size() - 1);
			text_q.push_back(c);
		end
	endfunction

	// Mostly short gaps, some none, a few long enough to land inside a conversion
	function automatic int pick_gap();
		int u;
		u = $urandom_range(0, 99);
		if (steady || u < 40) begin
			return 0;
		end
		if (u < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 400);
	endfunction

	// Random value: full range, small magnitudes, extremes, near powers of the base, shifted randoms
	function automatic logic [31:0] pick_value(input logic [5:0] r);
		logic [31:0] v;
		logic [31:0] p;
		logic [31:0] b;
		int          sel;
		sel = $urandom_range(0, 9);
		b = {26'd0, clamp_radix(r)};
		if (sel <= 3) begin
			v = $urandom;
		end else if (sel <= 5) begin
			v = $urandom_range(0, 100);
			if ($urandom_range(0, 1) == 1) v = -v;
		end else if (sel == 6) begin
			case ($urandom_range(0, 4))
				0: v = 32'h0000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'h8000_0000;
				3: v = 32'hFFFF_FFFF;
				default: v = 32'h0000_0001;
			endcase
		end else if (sel == 7) begin
			p = 32'd1;
			repeat ($urandom_range(1, 31)) begin
				if (p <= 32'h7FFF_FFFF / b) p = p * b;
			end
			v = p + $urandom_range(0, 2) - 1;
			if ($urandom_range(0, 1) == 1) v = -v;
		end else begin
			v = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1) == 1) v = -v;
		end
		return v;
	endfunction

	// Driver: predict on each accepted transaction, then issue the next value
	always @(posedge clk) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left = 0;
		end else begin
			if (radix_we) begin
				radix_shadow = radix_wdata;
			end
			if (start && !busy) begin
				queue_text(value, radix_shadow);
				gap_left = pick_gap();
			end
			if (start && busy) begin
				// held until the block takes it
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (pending_q.size() > 0) begin
				start <= 1'b1;
				value <= pending_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed character against the oldest expectation
	always @(posedge clk) begin
		ascii_char_t exp_c;
		if (arst_n && valid === 1'b1) begin
			if (text_q.size() == 0) begin
				$display("%0t: unexpected char: expected none, actual %h last %b",
				         $time, char_code, last);
				mismatch_count++;
			end else begin
				exp_c = text_q.pop_front();
				if (char_code !== exp_c.code) begin
					$display("%0t: char_code: expected %h, actual %h",
					         $time, exp_c.code, char_code);
					mismatch_count++;
				end
				if (last !== exp_c.fin) begin
					$display("%0t: last: expected %b, actual %b", $time, exp_c.fin, last);
					mismatch_count++;
				end
			end
		end
	end

	// Wait until every value is taken and all of its text has come out
	task automatic drain();
		do @(negedge clk);
		while (pending_q.size() != 0 || start || busy || text_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// One phase: optional radix write while idle, fixed values, then random ones
	task automatic run_phase(input logic [5:0] r, input bit do_write, input int n_random);
		if (do_write) begin
			@(posedge clk);
			radix_we    <= 1'b1;
			radix_wdata <= r;
			@(posedge clk);
			radix_we    <= 1'b0;
			@(negedge clk);
		end
		steady = ($urandom_range(0, 3) == 0);
		while (directed_q.size() > 0) begin
			pending_q.push_back(directed_q.pop_front());
		end
		repeat (n_random) pending_q.push_back(pick_value(r));
		drain();
	endtask

	// Stimulus sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset radix of ten: zero, signs, decimal edges, both extremes
		directed_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10,
		               32'h7FFF_FFFF, 32'h8000_0000, 32'd123456789, -32'd987654321,
		               32'h5555_5555, 32'hAAAA_AAAA};
		run_phase(RADIX_RESET, 1'b0, 40);

		// top radix: highest digit Z, its carry into two digits, both extremes
		directed_q = '{32'd35, 32'd36, -32'd35, 32'd1295, 32'h7FFF_FFFF, 32'h8000_0000};
		run_phase(RADIX_MAX, 1'b1, 30);

		// binary: longest texts
		directed_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		run_phase(RADIX_MIN, 1'b1, 30);

		run_phase(6'd16, 1'b1, 30);
		run_phase(6'd8, 1'b1, 25);

		// out-of-range register values saturate
		run_phase(6'd0, 1'b1, 15);
		run_phase(6'd1, 1'b1, 10);
		run_phase(6'd37, 1'b1, 15);
		run_phase(6'd63, 1'b1, 15);

		repeat (5) run_phase(6'($urandom_range(2, 36)), 1'b1, 15);

		repeat (40) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#60_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
